### hdl/ptb_pkg.sv
`default_nettype none
package ptb_pkg;

	localparam int DEF_POOL_PAGES    = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_BITS          = $clog2(ENTRIES_PER_TABLE);
	localparam int PAGE_SHIFT        = 12;
	localparam int ADDR_W            = 48;
	localparam int FLAGS_W           = 64;

	// virtual address bit positions of the level 0..3 table indexes
	localparam int L0_SHIFT = 39;
	localparam int L1_SHIFT = 30;
	localparam int L2_SHIFT = 21;
	localparam int L3_SHIFT = 12;

	localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
	localparam logic [1:0] CFG_PAGE_COUNT = 2'd1;
	localparam logic [1:0] CFG_TABLE_TAG  = 2'd2;

	localparam logic [47:0] POOL_BASE_RST  = 48'd0;
	localparam logic [6:0]  PAGE_COUNT_RST = 7'd64;
	localparam logic [11:0] TABLE_TAG_RST  = 12'd3;

	typedef enum logic [1:0] {
		OP_MAP    = 2'd0,
		OP_ENSURE = 2'd1,
		OP_FIND   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_NOT_FOUND = 2'd2
	} sts_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_RD,
		S_EVAL,
		S_LEAF,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic follow;
		logic alloc;
		logic take_addr;
		logic leaf;
		logic set_sts;
		sts_t sts_code;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic clr_last;
		logic link_zero;
		logic pool_empty;
		logic last_lvl;
		logic in_range;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

### hdl/ptb_ctrl.sv
`default_nettype none
module ptb_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire ptb_pkg::dp_sts_t sts,
	output ptb_pkg::cmd_t   cmd
);

	ptb_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptb_pkg::S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ptb_pkg::S_CLEAR: begin
				if (sts.clr_last) state_nx = ptb_pkg::S_IDLE;
			end
			ptb_pkg::S_IDLE: begin
				if (in_valid) state_nx = ptb_pkg::S_CHECK;
			end
			ptb_pkg::S_CHECK: begin
				unique case (sts.op)
					ptb_pkg::OP_MAP:    state_nx = sts.in_range ? ptb_pkg::S_RD : ptb_pkg::S_DONE;
					ptb_pkg::OP_ENSURE,
					ptb_pkg::OP_FIND:   state_nx = ptb_pkg::S_RD;
					default:            state_nx = ptb_pkg::S_DONE;
				endcase
			end
			ptb_pkg::S_RD: begin
				state_nx = ptb_pkg::S_EVAL;
			end
			ptb_pkg::S_EVAL: begin
				priority if (sts.link_zero && sts.op == ptb_pkg::OP_FIND) begin
					state_nx = ptb_pkg::S_DONE;
				end else if (sts.link_zero && sts.pool_empty) begin
					state_nx = ptb_pkg::S_DONE;
				end else if (!sts.last_lvl) begin
					state_nx = ptb_pkg::S_RD;
				end else begin
					state_nx = (sts.op == ptb_pkg::OP_MAP) ? ptb_pkg::S_LEAF : ptb_pkg::S_DONE;
				end
			end
			ptb_pkg::S_LEAF: begin
				state_nx = ptb_pkg::S_CHECK;
			end
			ptb_pkg::S_DONE: begin
				if (sts.out_free) state_nx = ptb_pkg::S_IDLE;
			end
			default: state_nx = ptb_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.sts_code = ptb_pkg::ST_OK;
		in_ready     = 1'b0;
		unique case (state_q)
			ptb_pkg::S_CLEAR: cmd.clr = 1'b1;
			ptb_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ptb_pkg::S_RD:    cmd.rd = 1'b1;
			ptb_pkg::S_EVAL: begin
				priority if (sts.link_zero && sts.op == ptb_pkg::OP_FIND) begin
					cmd.set_sts  = 1'b1;
					cmd.sts_code = ptb_pkg::ST_NOT_FOUND;
				end else if (sts.link_zero && sts.pool_empty) begin
					cmd.set_sts  = 1'b1;
					cmd.sts_code = ptb_pkg::ST_EXHAUSTED;
				end else begin
					cmd.follow    = !sts.link_zero;
					cmd.alloc     = sts.link_zero;
					cmd.take_addr = sts.last_lvl && sts.op != ptb_pkg::OP_MAP;
				end
			end
			ptb_pkg::S_LEAF:  cmd.leaf = 1'b1;
			ptb_pkg::S_DONE:  cmd.res_load = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### hdl/ptb_datapath.sv
`default_nettype none
module ptb_datapath #(
	parameter int POOL_PAGES = ptb_pkg::DEF_POOL_PAGES
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [1:0]                  cfg_index,
	input  wire  [ptb_pkg::ADDR_W-1:0]  cfg_data,
	input  wire  [1:0]                  opcode,
	input  wire  [ptb_pkg::ADDR_W-1:0]  virt_start,
	input  wire  [ptb_pkg::ADDR_W-1:0]  virt_end,
	input  wire  [ptb_pkg::ADDR_W-1:0]  phys_start,
	input  wire  [ptb_pkg::FLAGS_W-1:0] attr_flags,
	input  wire                         out_ready,
	output logic                        out_valid,
	output logic [1:0]                  status,
	output logic [ptb_pkg::ADDR_W-1:0]  table_addr,
	input  wire ptb_pkg::cmd_t          cmd,
	output ptb_pkg::dp_sts_t            sts
);

	localparam int PW    = $clog2(POOL_PAGES);
	localparam int NW    = $clog2(POOL_PAGES + 1);
	localparam int CW    = (NW > 7) ? NW : 7;
	localparam int AW    = PW + ptb_pkg::IDX_BITS;
	localparam int DEPTH = POOL_PAGES * ptb_pkg::ENTRIES_PER_TABLE;
	localparam int WW    = ptb_pkg::FLAGS_W + PW;
	localparam int HW    = ptb_pkg::ADDR_W - ptb_pkg::PAGE_SHIFT;

	// each word: link page above the 64-bit descriptor; link zero means no table
	logic [WW-1:0] mem [DEPTH];

	logic [47:0]  pool_base_q;
	logic [6:0]   page_count_q;
	logic [11:0]  tag_q;

	ptb_pkg::op_t op_q;
	logic [48:0]  va_q;
	logic [47:0]  ve_q;
	logic [47:0]  phys_q;
	logic [63:0]  flags_q;
	logic [1:0]   lvl_q;
	logic [PW-1:0] page_q;
	logic [NW-1:0] nfp_q;
	logic [AW-1:0] clr_q;
	logic [WW-1:0] rd_q;
	ptb_pkg::sts_t sts_q;
	logic [47:0]  addr_q;

	logic          out_valid_q;
	ptb_pkg::sts_t out_sts_q;
	logic [47:0]   out_addr_q;

	logic [ptb_pkg::IDX_BITS-1:0] idx;
	logic [AW-1:0]  ent_addr;
	logic [47:0]    new_desc;
	logic [PW-1:0]  link;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [WW-1:0]  wr_data;

	always_comb begin
		unique case (lvl_q)
			2'd0:    idx = va_q[ptb_pkg::L0_SHIFT +: ptb_pkg::IDX_BITS];
			2'd1:    idx = va_q[ptb_pkg::L1_SHIFT +: ptb_pkg::IDX_BITS];
			default: idx = va_q[ptb_pkg::L2_SHIFT +: ptb_pkg::IDX_BITS];
		endcase
	end

	assign ent_addr = {page_q, idx};
	assign link     = rd_q[WW-1:ptb_pkg::FLAGS_W];
	assign new_desc = {pool_base_q[47:ptb_pkg::PAGE_SHIFT] + HW'(nfp_q), tag_q};

	always_comb begin
		sts.op         = op_q;
		sts.clr_last   = (clr_q == AW'(DEPTH - 1));
		sts.link_zero  = (link == '0);
		sts.pool_empty = (CW'(nfp_q) >= CW'(page_count_q)) || (nfp_q >= NW'(POOL_PAGES));
		sts.last_lvl   = (op_q == ptb_pkg::OP_FIND) ? (lvl_q == 2'd1) : (lvl_q == 2'd2);
		sts.in_range   = (va_q < {1'b0, ve_q});
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ent_addr;
		wr_data = '0;
		priority if (cmd.clr) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (cmd.alloc) begin
			wr_en   = 1'b1;
			wr_data = {nfp_q[PW-1:0], 16'd0, new_desc};
		end else if (cmd.leaf) begin
			wr_en   = 1'b1;
			wr_addr = {page_q, va_q[ptb_pkg::L3_SHIFT +: ptb_pkg::IDX_BITS]};
			wr_data = {{PW{1'b0}}, {16'd0, phys_q} | flags_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_q <= mem[ent_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= ptb_pkg::POOL_BASE_RST;
			page_count_q <= ptb_pkg::PAGE_COUNT_RST;
			tag_q        <= ptb_pkg::TABLE_TAG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptb_pkg::CFG_POOL_BASE:  pool_base_q  <= cfg_data;
				ptb_pkg::CFG_PAGE_COUNT: page_count_q <= cfg_data[6:0];
				ptb_pkg::CFG_TABLE_TAG:  tag_q        <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			nfp_q <= NW'(1);
		end else begin
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			if (cmd.alloc) nfp_q <= nfp_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= ptb_pkg::op_t'(opcode);
			va_q    <= {1'b0, virt_start};
			ve_q    <= virt_end;
			phys_q  <= phys_start;
			flags_q <= attr_flags;
			lvl_q   <= 2'd0;
			page_q  <= '0;
			sts_q   <= ptb_pkg::ST_OK;
			addr_q  <= '0;
		end else begin
			if (cmd.follow) page_q <= link;
			if (cmd.alloc) page_q <= nfp_q[PW-1:0];
			if (cmd.follow || cmd.alloc) lvl_q <= lvl_q + 2'd1;
			if (cmd.take_addr) begin
				addr_q <= cmd.alloc ? {new_desc[47:ptb_pkg::PAGE_SHIFT], 12'd0}
				                    : {rd_q[47:ptb_pkg::PAGE_SHIFT], 12'd0};
			end
			if (cmd.set_sts) sts_q <= cmd.sts_code;
			if (cmd.leaf) begin
				va_q   <= va_q + 49'd4096;
				phys_q <= phys_q + 48'd4096;
				lvl_q  <= 2'd0;
				page_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_sts_q  <= sts_q;
			out_addr_q <= addr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_sts_q;
	assign table_addr = out_addr_q;

endmodule
`default_nettype wire

### hdl/page_table_builder_top.sv
`default_nettype none
// Four-level translation table builder, 4 KiB granule, tables kept in an internal pool.
// Request channel: in_valid/in_ready with opcode, virt_start, virt_end, phys_start,
// attr_flags. Result channel: out_valid/out_ready with status and table_addr, one
// result per request. Configuration: cfg_we/cfg_index/cfg_data, written while idle.
// Steps, from acceptance of a request to the load of the result register:
//   no-op or empty range: the range check only
//   find_directory: one read/evaluate pair per level walked, down to level 1
//   ensure_table: one read/evaluate pair per level walked, down to level 2
//   map_range: each 4 KiB page takes three dependent read/evaluate pairs on the
//   table memory, a leaf write and a range check.
// in_ready returns in the cycle after the result loads.
// The next request is taken once the result has moved into the output register,
// so one result may wait on a stalled receiver while the next request runs; a
// second finished result then holds the block until out_ready.
// After reset the table memory is cleared one word per cycle, all POOL_PAGES * 512
// words (32768 by default); in_ready stays low meanwhile, configuration writes
// are taken as usual.
module page_table_builder_top #(
	parameter int POOL_PAGES = ptb_pkg::DEF_POOL_PAGES
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [1:0]                  cfg_index,
	input  wire  [ptb_pkg::ADDR_W-1:0]  cfg_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [1:0]                  opcode,
	input  wire  [ptb_pkg::ADDR_W-1:0]  virt_start,
	input  wire  [ptb_pkg::ADDR_W-1:0]  virt_end,
	input  wire  [ptb_pkg::ADDR_W-1:0]  phys_start,
	input  wire  [ptb_pkg::FLAGS_W-1:0] attr_flags,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [1:0]                  status,
	output logic [ptb_pkg::ADDR_W-1:0]  table_addr
);

	ptb_pkg::cmd_t    cmd;
	ptb_pkg::dp_sts_t sts;

	ptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptb_datapath #(
		.POOL_PAGES (POOL_PAGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.opcode     (opcode),
		.virt_start (virt_start),
		.virt_end   (virt_end),
		.phys_start (phys_start),
		.attr_flags (attr_flags),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.status     (status),
		.table_addr (table_addr),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
`default_nettype wire
